// ===== src/stb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and constants of the software timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = 4;
   localparam int PERIOD_W   = 31;
   localparam int REMAIN_W   = 32;
   localparam int ELAPSED_W  = 16;
   localparam int WORD_W     = PERIOD_W + REMAIN_W;
   localparam int DIVIDEND_W = REMAIN_W + 1;

   typedef enum logic [2:0] {
      ACT_TICK         = 3'd0,
      ACT_START        = 3'd1,
      ACT_DESTROY      = 3'd2,
      ACT_SET_PAUSE    = 3'd3,
      ACT_POLL         = 3'd4,
      ACT_QUERY_PAUSED = 3'd5,
      ACT_QUERY_EXISTS = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_SHORT   = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_TICK_MOD,
      ST_DONE
   } state_type;

endpackage

// ===== src/stb_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb channels
// request, response and register write channels of the timer bank
// ----------------------------------------------------------------------------
interface stb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [3:0]  timer_id;
   logic [30:0] interval;
   logic        one_shot;
   logic        pause_value;
   logic [15:0] elapsed;
   modport source (output valid, action, timer_id, interval, one_shot, pause_value, elapsed,
                   input ready);
   modport sink (input valid, action, timer_id, interval, one_shot, pause_value, elapsed,
                 output ready);
endinterface

interface stb_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] id_out;
   logic       answer;
   logic [1:0] status;
   modport source (output valid, id_out, answer, status, input ready);
   modport sink (input valid, id_out, answer, status, output ready);
endinterface

interface stb_csr_if;
   logic        valid;
   logic        ready;
   logic [30:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== src/software_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_bank
// sixteen slot timer bank, period and remaining time held in one ram
// ----------------------------------------------------------------------------
// destroy, pause, poll and queries are settled in ST_IDLE and pass ST_DONE to the response register
// start scans one slot per cycle from the pointer
// tick visits the slots in ST_TICK_RD, an active slot adds ST_TICK_CHK, and a reload
// with a nonzero period waits in ST_TICK_MOD for the bit serial remainder unit
// one item at a time; a new beat is taken while the previous response waits
// reset is synchronous and clears flags, pointer and min_interval (to 1)
module software_timer_bank (
   input  logic clock,
   input  logic reset,
   stb_req_if.sink   req_chan,
   stb_rsp_if.source rsp_chan,
   stb_csr_if.sink   csr_chan
);
   import stb_pkg::*;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     ptr_ff, ptr_in;
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [SLOT_COUNT-1:0] paused_ff, paused_in;
   logic [SLOT_COUNT-1:0] ticked_ff, ticked_in;
   logic [SLOT_COUNT-1:0] shot_ff, shot_in;
   logic [PERIOD_W-1:0]   min_ff;
   logic [PERIOD_W-1:0]   interval_ff, interval_in;
   logic                  kind_ff, kind_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [PERIOD_W-1:0]   per_ff, per_in;
   logic [SLOT_W-1:0]     res_id_ff, res_id_in;
   logic                  res_answer_ff, res_answer_in;
   status_type            res_status_ff, res_status_in;
   logic                  out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0]     out_id_ff, out_id_in;
   logic                  out_answer_ff, out_answer_in;
   logic [1:0]            out_status_ff, out_status_in;

   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_waddr;
   logic [WORD_W-1:0]     ram_wdata;
   logic [WORD_W-1:0]     ram_rdata;
   logic [PERIOD_W-1:0]   rd_period;
   logic [REMAIN_W-1:0]   rd_remain;
   logic [DIVIDEND_W-1:0] diff;
   logic [DIVIDEND_W-1:0] neg_diff;
   logic                  mod_start;
   logic                  mod_done;
   logic [PERIOD_W-1:0]   mod_rem;
   logic [SLOT_W-1:0]     scan_idx;
   logic [SLOT_W-1:0]     req_idx;
   logic                  advance;

   stb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (count_ff),
      .rdata (ram_rdata)
   );

   stb_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (neg_diff),
      .divisor   (per_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rd_period = ram_rdata[WORD_W-1:REMAIN_W];
   assign rd_remain = ram_rdata[REMAIN_W-1:0];
   assign diff      = {rd_remain[REMAIN_W-1], rd_remain}
                      - {{(DIVIDEND_W-ELAPSED_W){1'b0}}, elapsed_ff};
   assign neg_diff  = DIVIDEND_W'(~diff + 1'b1);
   assign scan_idx  = ptr_ff + count_ff;
   assign req_idx   = req_chan.timer_id;
   assign ram_waddr = (state_ff == ST_SCAN) ? scan_idx : count_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.id_out = out_id_ff;
   assign rsp_chan.answer = out_answer_ff;
   assign rsp_chan.status = out_status_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      paused_in     = paused_ff;
      ticked_in     = ticked_ff;
      shot_in       = shot_ff;
      interval_in   = interval_ff;
      kind_in       = kind_ff;
      elapsed_in    = elapsed_ff;
      per_in        = per_ff;
      res_id_in     = res_id_ff;
      res_answer_in = res_answer_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff & ~rsp_chan.ready;
      out_id_in     = out_id_ff;
      out_answer_in = out_answer_ff;
      out_status_in = out_status_ff;
      ram_we        = 1'b0;
      ram_wdata     = {interval_ff, 1'b0, interval_ff};
      mod_start     = 1'b0;
      advance       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               interval_in   = req_chan.interval;
               kind_in       = req_chan.one_shot;
               elapsed_in    = req_chan.elapsed;
               count_in      = '0;
               res_id_in     = '0;
               res_answer_in = 1'b0;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               if (req_chan.action == ACT_TICK) begin
                  state_in = ST_TICK_RD;
               end else if (req_chan.action == ACT_START) begin
                  state_in = ST_SCAN;
               end else if (req_chan.action == ACT_QUERY_EXISTS) begin
                  res_answer_in = valid_ff[req_idx];
               end else if (req_chan.action == ACT_DESTROY
                            || req_chan.action == ACT_SET_PAUSE
                            || req_chan.action == ACT_POLL
                            || req_chan.action == ACT_QUERY_PAUSED) begin
                  if (!valid_ff[req_idx]) begin
                     res_status_in = STATUS_MISSING;
                  end else if (req_chan.action == ACT_DESTROY) begin
                     valid_in[req_idx] = 1'b0;
                  end else if (req_chan.action == ACT_SET_PAUSE) begin
                     paused_in[req_idx] = req_chan.pause_value;
                  end else if (req_chan.action == ACT_POLL) begin
                     if (!paused_ff[req_idx] && ticked_ff[req_idx]) begin
                        ticked_in[req_idx] = 1'b0;
                        res_answer_in      = 1'b1;
                        if (shot_ff[req_idx]) begin
                           valid_in[req_idx] = 1'b0;
                        end
                     end
                  end else begin
                     res_answer_in = paused_ff[req_idx];
                  end
               end
            end
         end
         ST_SCAN: begin
            if (!valid_ff[scan_idx]) begin
               ptr_in   = scan_idx;
               state_in = ST_DONE;
               if (interval_ff < min_ff) begin
                  res_status_in = STATUS_SHORT;
               end else begin
                  valid_in[scan_idx]  = 1'b1;
                  paused_in[scan_idx] = 1'b0;
                  ticked_in[scan_idx] = 1'b0;
                  shot_in[scan_idx]   = kind_ff;
                  res_id_in           = scan_idx;
                  count_in            = scan_idx;
                  ram_we              = 1'b1;
               end
            end else if (count_ff == SLOT_W'(SLOT_COUNT - 1)) begin
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_TICK_RD: begin
            if (valid_ff[count_ff] && !paused_ff[count_ff]) begin
               state_in = ST_TICK_CHK;
            end else begin
               advance = 1'b1;
            end
         end
         ST_TICK_CHK: begin
            per_in = rd_period;
            if (!diff[DIVIDEND_W-1]) begin
               ram_we    = 1'b1;
               ram_wdata = {rd_period, diff[REMAIN_W-1:0]};
               advance   = 1'b1;
            end else begin
               ticked_in[count_ff] = 1'b1;
               if (rd_period == '0) begin
                  ram_we    = 1'b1;
                  ram_wdata = {rd_period, {REMAIN_W{1'b0}}};
                  advance   = 1'b1;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_TICK_MOD;
               end
            end
         end
         ST_TICK_MOD: begin
            if (mod_done) begin
               ram_we = 1'b1;
               if (mod_rem == '0) begin
                  ram_wdata = {per_ff, {REMAIN_W{1'b0}}};
               end else begin
                  ram_wdata = {per_ff, 1'b0, PERIOD_W'(per_ff - mod_rem)};
               end
               advance = 1'b1;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in  = 1'b1;
               out_id_in     = res_id_ff;
               out_answer_in = res_answer_ff;
               out_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (count_ff == SLOT_W'(SLOT_COUNT - 1)) begin
            state_in = ST_DONE;
         end else begin
            count_in = count_ff + 1'b1;
            state_in = ST_TICK_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         paused_ff    <= '0;
         ticked_ff    <= '0;
         shot_ff      <= '0;
         min_ff       <= PERIOD_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         paused_ff    <= paused_in;
         ticked_ff    <= ticked_in;
         shot_ff      <= shot_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            min_ff <= csr_chan.data;
         end
      end
      interval_ff   <= interval_in;
      kind_ff       <= kind_in;
      elapsed_ff    <= elapsed_in;
      per_ff        <= per_in;
      res_id_ff     <= res_id_in;
      res_answer_ff <= res_answer_in;
      res_status_ff <= res_status_in;
      out_id_ff     <= out_id_in;
      out_answer_ff <= out_answer_in;
      out_status_ff <= out_status_in;
   end

   a_mod_slot_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK_MOD |-> valid_ff[count_ff] && ticked_ff[count_ff])
      else $error("reload running on an inactive slot");

   a_ptr_moves_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |=> $stable(ptr_ff))
      else $error("slot pointer moved outside start scan");

   a_ram_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_SCAN || state_ff == ST_TICK_CHK || state_ff == ST_TICK_MOD))
      else $error("ram written in an unexpected state");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");
endmodule

// ===== src/stb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module stb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/stb_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_mod
// bit serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module stb_mod (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [stb_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [stb_pkg::PERIOD_W-1:0]       divisor,
   output logic                               done,
   output logic [stb_pkg::PERIOD_W-1:0]       remainder
);
   import stb_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [PERIOD_W-1:0]   acc_ff, acc_in;
   logic [PERIOD_W:0]     acc_shift;
   logic [PERIOD_W:0]     div_ext;

   assign acc_shift = {acc_ff, shift_ff[DIVIDEND_W-1]};
   assign div_ext   = {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = STEPS;
         shift_in = dividend;
         acc_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         if (acc_shift >= div_ext) begin
            acc_in = PERIOD_W'(acc_shift - div_ext);
         end else begin
            acc_in = acc_shift[PERIOD_W-1:0];
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign done      = done_ff;
   assign remainder = acc_ff;
endmodule
